[design/rcd_pkg.sv]
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types, constants and the FNV-1a byte step for the region change
// detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcd_pkg;

    // FNV-1a 64-bit constants
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    // Default number of watched regions
    localparam int NUM_REGIONS_DEF = 1024;

    // Field widths
    localparam int REGION_W = 10;
    localparam int BYTE_W   = 8;
    localparam int EPOCH_W  = 32;
    localparam int HASH_W   = 64;

    // Stream widths (tdata padded to whole bytes)
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 112;

    // One memory word holds the baseline hash over the epoch
    localparam int MEM_W = HASH_W + EPOCH_W;

    typedef enum logic
    {
        OP_TRACK = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [HASH_W-1:0]   hash;
        logic [EPOCH_W-1:0]  epoch;
        logic                changed;
        logic [REGION_W-1:0] region;
    } result_t;

    // Fold one byte: xor, then multiply by the prime 2^40 + 2^8 + 0xB3
    // as a sum of shifted copies.
    function automatic logic [HASH_W-1:0] fnv_step(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] x;
        begin
            x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
            fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                     + (x << 4) + (x << 1) + x;
        end
    endfunction

endpackage

[design/rcd_ram.sv]
// ----------------------------------------------------------------------------
// rcd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcd_ram #(
    parameter int WIDTH = rcd_pkg::MEM_W,
    parameter int DEPTH = rcd_pkg::NUM_REGIONS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

[design/region_change_detector.sv]
// ----------------------------------------------------------------------------
// region_change_detector: FNV-1a 64 region hashing with change detection
// A last byte's pass is registered in stage 1, then pushed into the result queue.
// Throughput: one byte per cycle while s_tready is high; the shift-add hash step is combinational.
// Reset (rst_n low, async) empties the pipe and restarts the hash at basis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module region_change_detector #(
    parameter int NUM_REGIONS = rcd_pkg::NUM_REGIONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rcd_pkg::IN_TDATA_W-1:0] s_tdata,   // [9:0] region_num, [17:10] data_byte
    input  logic                           s_tuser,   // [0] op
    input  logic                           s_tlast,   // last_byte

    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rcd_pkg::OUT_TDATA_W-1:0] m_tdata,  // [9:0] region_out, [41:10] epoch_out,
                                                      // [105:42] hash_out
    output logic                            m_tuser   // [0] changed
);

    localparam int AW   = $clog2(NUM_REGIONS);
    localparam int EXTW = 17;   // wide enough for any region count in range

    // ------------------------------------------------------------------
    // Stage 0: take a byte, fold it into the running hash. A last byte
    // launches the memory read of its region's baseline and epoch.
    // ------------------------------------------------------------------
    logic                         in_fire;
    rcd_pkg::op_t                 in_op;
    logic [rcd_pkg::REGION_W-1:0] in_region;
    logic [rcd_pkg::BYTE_W-1:0]   in_byte;
    logic [EXTW-1:0]              in_region_ext;
    logic                         in_in_range;
    logic [AW-1:0]                in_addr;
    logic [rcd_pkg::HASH_W-1:0]   in_hash;

    logic [rcd_pkg::HASH_W-1:0]   run_hash_reg;
    logic [rcd_pkg::HASH_W-1:0]   run_hash_next;

    assign in_fire       = s_tvalid && s_tready;
    assign in_op         = rcd_pkg::op_t'(s_tuser);
    assign in_region     = s_tdata[rcd_pkg::REGION_W-1:0];
    assign in_byte       = s_tdata[rcd_pkg::REGION_W +: rcd_pkg::BYTE_W];
    assign in_region_ext = EXTW'(in_region);
    assign in_in_range   = in_region_ext < EXTW'(NUM_REGIONS);
    assign in_addr       = in_region_ext[AW-1:0];
    assign in_hash       = rcd_pkg::fnv_step(run_hash_reg, in_byte);

    // Restart at the offset basis after a last byte, else carry the hash on.
    always_comb
    begin
        run_hash_next = run_hash_reg;
        if (in_fire)
        begin
            run_hash_next = s_tlast ? rcd_pkg::FNV_BASIS : in_hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash_reg <= rcd_pkg::FNV_BASIS;
        end
        else
        begin
            run_hash_reg <= run_hash_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers: the finished pass waiting for its memory word.
    // ------------------------------------------------------------------
    logic                         s1_valid_reg;
    rcd_pkg::op_t                 s1_op_reg;
    logic [rcd_pkg::REGION_W-1:0] s1_region_reg;
    logic                         s1_in_range_reg;
    logic [AW-1:0]                s1_addr_reg;
    logic [rcd_pkg::HASH_W-1:0]   s1_hash_reg;

    // Forwarding: a write in the same cycle as the read of the same entry
    // is not seen by the RAM, so hold the written word beside it.
    logic                         fwd_hit_reg;
    logic [rcd_pkg::MEM_W-1:0]    fwd_data_reg;

    logic                         wr_en;
    logic [rcd_pkg::MEM_W-1:0]    wr_data;
    logic [rcd_pkg::MEM_W-1:0]    rd_data;
    logic [rcd_pkg::MEM_W-1:0]    cur_word;
    logic [rcd_pkg::HASH_W-1:0]   base_hash;
    logic [rcd_pkg::EPOCH_W-1:0]  base_epoch;
    logic                         s1_changed;
    logic [rcd_pkg::EPOCH_W-1:0]  s1_epoch_out;
    logic [rcd_pkg::EPOCH_W-1:0]  new_epoch;

    rcd_ram #(
        .WIDTH (rcd_pkg::MEM_W),
        .DEPTH (NUM_REGIONS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    assign cur_word   = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign base_hash  = cur_word[rcd_pkg::EPOCH_W +: rcd_pkg::HASH_W];
    assign base_epoch = cur_word[rcd_pkg::EPOCH_W-1:0];

    // Read-modify-write of the region entry
    always_comb
    begin
        s1_changed   = 1'b0;
        s1_epoch_out = '0;
        new_epoch    = '0;
        wr_en        = 1'b0;
        if (s1_valid_reg && s1_in_range_reg)
        begin
            unique case (s1_op_reg)
                rcd_pkg::OP_TRACK:
                begin
                    // Set the baseline, clear the epoch.
                    wr_en = 1'b1;
                end
                rcd_pkg::OP_CHECK:
                begin
                    s1_epoch_out = base_epoch;
                    s1_changed   = s1_hash_reg != base_hash;
                    new_epoch    = base_epoch + rcd_pkg::EPOCH_W'(1);
                    // Replace the baseline and advance the epoch on a change.
                    wr_en        = s1_changed;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    assign wr_data = {s1_hash_reg, new_epoch};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire && s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg       <= in_op;
        s1_region_reg   <= in_region;
        s1_in_range_reg <= in_in_range;
        s1_addr_reg     <= in_addr;
        s1_hash_reg     <= in_hash;
        fwd_hit_reg     <= wr_en && (s1_addr_reg == in_addr);
        fwd_data_reg    <= wr_data;
    end

    // ------------------------------------------------------------------
    // Result queue: four entries. The input is held off only when the
    // queue plus the pass in stage 1 could fill it, so no path runs from
    // m_tready to s_tready and a byte enters every cycle while results flow.
    // ------------------------------------------------------------------
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    rcd_pkg::result_t   q_mem_reg [QDEPTH];
    logic [QAW-1:0]     q_head_reg;
    logic [QAW-1:0]     q_tail_reg;
    logic [QAW:0]       q_count_reg;
    logic [QAW:0]       q_count_next;
    logic               q_push;
    logic               q_pop;
    rcd_pkg::result_t   q_in;
    rcd_pkg::result_t   q_out;

    assign q_push = s1_valid_reg;
    assign q_pop  = m_tvalid && m_tready;

    assign q_in.hash    = s1_hash_reg;
    assign q_in.epoch   = s1_epoch_out;
    assign q_in.changed = s1_changed;
    assign q_in.region  = s1_region_reg;

    assign q_count_next = q_count_reg + (QAW+1)'(q_push) - (QAW+1)'(q_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (q_push)
            begin
                q_tail_reg <= q_tail_reg + QAW'(1);
            end
            if (q_pop)
            begin
                q_head_reg <= q_head_reg + QAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[q_tail_reg] <= q_in;
        end
    end

    assign s_tready = (q_count_reg + (QAW+1)'(s1_valid_reg)) < (QAW+1)'(QDEPTH);

    assign q_out    = q_mem_reg[q_head_reg];
    assign m_tvalid = q_count_reg != '0;
    assign m_tuser  = q_out.changed;
    assign m_tdata  = {
        {(rcd_pkg::OUT_TDATA_W - rcd_pkg::HASH_W - rcd_pkg::EPOCH_W - rcd_pkg::REGION_W){1'b0}},
        q_out.hash, q_out.epoch, q_out.region
    };

endmodule

[design/rcd_checker.sv]
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks on the region change detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rcd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    // No result is offered once reset has been seen at an edge.
    a_no_result_in_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The last byte of a pass has its result offered after passing stage 1 into the result queue.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid)
        else $error("missing result after last byte");

    // A result appears only after a last byte has been taken and passed through stage 1.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a finished pass");

    // Requests are held off only while results back up.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("request stalled with no result pending");

endmodule

bind region_change_detector rcd_checker u_rcd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/region_hash_checker.sv]
// ----------------------------------------------------------------------------
// region_hash_checker
// Watches both streams of the region change detector. It predicts each
// finished pass (FNV-1a 64 hash, change flag, epoch) and compares the
// results, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module region_hash_checker (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rcd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [9:0] region_num, [17:10] data_byte
    input  logic                            s_tuser,   // [0] op
    input  logic                            s_tlast,   // last_byte

    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rcd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [9:0] region_out, [41:10] epoch_out,
                                                       // [105:42] hash_out
    input  logic                            m_tuser,   // [0] changed

    output int                              mismatch_count,
    output int                              results_waiting,
    output int                              results_seen,
    output int                              changes_seen
);

    localparam int          REGION_SLOTS = rcd_pkg::NUM_REGIONS_DEF;
    localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;

    logic [rcd_pkg::HASH_W-1:0]   running_hash;
    logic [rcd_pkg::HASH_W-1:0]   pass_hash;
    logic [rcd_pkg::HASH_W-1:0]   base_hash [REGION_SLOTS];
    logic [rcd_pkg::EPOCH_W-1:0]  region_epoch [REGION_SLOTS];
    logic [rcd_pkg::REGION_W-1:0] in_region;
    logic [rcd_pkg::BYTE_W-1:0]   in_byte;

    rcd_pkg::result_t             pass_result;
    rcd_pkg::result_t             oldest;
    rcd_pkg::result_t             pass_results [$];

    initial
    begin
        mismatch_count  = 0;
        results_waiting = 0;
        results_seen    = 0;
        changes_seen    = 0;
        for (int i = 0; i < REGION_SLOTS; i++)
        begin
            base_hash[i]    = '0;
            region_epoch[i] = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash = rcd_pkg::FNV_BASIS;
            pass_results.delete();
            results_waiting = 0;
        end
        else
        begin
            // fold the accepted byte; only the final byte's op and region count
            if (s_tvalid && s_tready)
            begin
                in_region = s_tdata[9:0];
                in_byte   = s_tdata[17:10];
                pass_hash = (running_hash ^ {56'd0, in_byte}) * FNV_PRIME;
                if (!s_tlast)
                begin
                    running_hash = pass_hash;
                end
                else
                begin
                    running_hash        = rcd_pkg::FNV_BASIS;
                    pass_result.region  = in_region;
                    pass_result.hash    = pass_hash;
                    pass_result.changed = 1'b0;
                    pass_result.epoch   = '0;
                    if (in_region < REGION_SLOTS)
                    begin
                        if (rcd_pkg::op_t'(s_tuser) == rcd_pkg::OP_TRACK)
                        begin
                            base_hash[in_region]    = pass_hash;
                            region_epoch[in_region] = '0;
                        end
                        else
                        begin
                            pass_result.epoch = region_epoch[in_region];
                            if (pass_hash != base_hash[in_region])
                            begin
                                pass_result.changed     = 1'b1;
                                base_hash[in_region]    = pass_hash;
                                region_epoch[in_region] = region_epoch[in_region]
                                                        + rcd_pkg::EPOCH_W'(1);
                            end
                        end
                    end
                    pass_results.push_back(pass_result);
                end
            end

            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tuser)
                    changes_seen++;
                if (pass_results.size() == 0)
                begin
                    mismatch_count++;
                    $error("unexpected result for region %0d, no pass outstanding",
                           m_tdata[9:0]);
                end
                else
                begin
                    oldest = pass_results.pop_front();
                    if (m_tdata[9:0] !== oldest.region)
                    begin
                        mismatch_count++;
                        $error("region_out: expected %0d, got %0d", oldest.region, m_tdata[9:0]);
                    end
                    if (m_tuser !== oldest.changed)
                    begin
                        mismatch_count++;
                        $error("changed: expected %0b, got %0b", oldest.changed, m_tuser);
                    end
                    if (m_tdata[41:10] !== oldest.epoch)
                    begin
                        mismatch_count++;
                        $error("epoch_out: expected %0d, got %0d", oldest.epoch, m_tdata[41:10]);
                    end
                    if (m_tdata[105:42] !== oldest.hash)
                    begin
                        mismatch_count++;
                        $error("hash_out: expected %h, got %h", oldest.hash, m_tdata[105:42]);
                    end
                end
            end

            results_waiting = pass_results.size();
        end
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: region change detector testbench
// Streams region bytes into the detector as track and check passes, with
// bursty requests and a stalling result side. A checker beside the block
// predicts every pass result; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int HOT_COUNT    = 12;   // regions revisited often, so checks repeat
    localparam int MAX_PASS     = 40;   // longest pass in bytes
    localparam int PHASE_ITEMS  = 325;  // bytes per random phase, four phases
    localparam int DRAIN_CYCLES = 8;    // margin after the last predicted result has come out

    // non-final bytes of a pass: how their op and region are disturbed
    localparam int NOISE_NONE   = 0;
    localparam int NOISE_INVERT = 1;
    localparam int NOISE_RANDOM = 2;

    typedef enum int
    {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_LONG_STALL
    } ready_style_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rcd_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // [9:0] region_num, [17:10] data_byte
    logic                            s_tuser  = 1'b0; // [0] op
    logic                            s_tlast  = 1'b0; // last_byte
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rcd_pkg::OUT_TDATA_W-1:0] m_tdata;         // [9:0] region_out, [41:10] epoch_out,
                                                      // [105:42] hash_out
    logic                            m_tuser;         // [0] changed

    int            mismatch_count;
    int            results_waiting;
    int            results_seen;
    int            changes_seen;

    ready_style_t  ready_style = READY_ALWAYS;
    logic [15:0]   stall_mask  = 16'b1011_0011_1000_1111;
    int            stall_count = 0;

    int            gap_max     = 0;   // longest sender gap; zero means no idling
    int            burst_left  = 0;
    int            items_sent  = 0;
    int            passes_sent = 0;

    bit                         tracked [1024];
    logic [rcd_pkg::REGION_W-1:0] hot_region [HOT_COUNT];
    logic [7:0]                 hot_bytes [HOT_COUNT][MAX_PASS];
    int                         hot_len [HOT_COUNT];
    logic [7:0]                 pass_buf [MAX_PASS];

    always #5 clk = ~clk;

    region_change_detector #(
        .NUM_REGIONS (rcd_pkg::NUM_REGIONS_DEF)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    region_hash_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting),
        .results_seen    (results_seen),
        .changes_seen    (changes_seen)
    );

    // Result side backpressure, one style per phase. Every style lets
    // m_tready come back high, so a drain always finishes.
    always @(negedge clk)
    begin
        case (ready_style)
            READY_ALWAYS:
                m_tready <= 1'b1;
            READY_RANDOM:
                m_tready <= ($urandom_range(0, 2) != 0);
            READY_PATTERN:
            begin
                stall_mask = {stall_mask[14:0], stall_mask[15]};
                m_tready  <= stall_mask[15];
            end
            default:
            begin
                // long stalls broken by short ready windows
                if (stall_count == 0)
                begin
                    stall_count = m_tready ? $urandom_range(5, 30) : $urandom_range(1, 4);
                    m_tready   <= ~m_tready;
                end
                else
                begin
                    stall_count--;
                end
            end
        endcase
    end

    // Present one request and hold it until accepted. Called and left at a
    // falling edge. Between bursts, unless gap_max is zero, drop tvalid for a random gap.
    task automatic send_byte(
        input rcd_pkg::op_t                 op,
        input logic [rcd_pkg::REGION_W-1:0] region,
        input logic [7:0]                   data,
        input logic                         last
    );
        int gap;
        if (burst_left == 0)
        begin
            if (gap_max > 0)
            begin
                gap = $urandom_range(1, gap_max);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, data, region};
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Send pass_buf[0..len-1] as one pass. Only the final byte's op and region
    // decide the pass, so earlier bytes may carry anything.
    task automatic send_pass(
        input rcd_pkg::op_t                 op,
        input logic [rcd_pkg::REGION_W-1:0] region,
        input int                           len,
        input int                           noise
    );
        logic [rcd_pkg::REGION_W-1:0] lead_region;
        rcd_pkg::op_t                 lead_op;
        for (int i = 0; i < len; i++)
        begin
            lead_region = region;
            lead_op     = op;
            if (i != len - 1)
            begin
                if (noise == NOISE_INVERT)
                begin
                    lead_region = ~region;
                    lead_op     = rcd_pkg::op_t'(~op);
                end
                else if (noise == NOISE_RANDOM && $urandom_range(0, 2) == 0)
                begin
                    lead_region = rcd_pkg::REGION_W'($urandom_range(0, 1023));
                    lead_op     = rcd_pkg::op_t'($urandom_range(0, 1));
                end
            end
            send_byte(lead_op, lead_region, pass_buf[i], i == len - 1);
        end
        if (op == rcd_pkg::OP_TRACK)
            tracked[region] = 1'b1;
        passes_sent++;
    endtask

    // One random pass. Hot regions remember their last contents, so a check
    // can replay them (no change) or replay them with one bit flipped.
    // A region is always tracked before it is first checked.
    task automatic random_pass();
        int                           slot;
        int                           len;
        int                           flip;
        int                           bit_sel;
        bit                           hot;
        logic [rcd_pkg::REGION_W-1:0] region;
        rcd_pkg::op_t                 op;
        hot    = ($urandom_range(0, 9) < 7);
        slot   = $urandom_range(0, HOT_COUNT - 1);
        region = hot ? hot_region[slot] : rcd_pkg::REGION_W'($urandom_range(0, 1023));
        op     = ($urandom_range(0, 9) < 7) ? rcd_pkg::OP_CHECK : rcd_pkg::OP_TRACK;
        if (!tracked[region])
            op = rcd_pkg::OP_TRACK;

        if (hot && op == rcd_pkg::OP_CHECK && hot_len[slot] > 0 && $urandom_range(0, 1) == 0)
        begin
            len = hot_len[slot];
            for (int i = 0; i < len; i++)
                pass_buf[i] = hot_bytes[slot][i];
            if ($urandom_range(0, 2) == 0)
            begin
                flip          = $urandom_range(0, len - 1);
                bit_sel       = $urandom_range(0, 7);
                pass_buf[flip] = pass_buf[flip] ^ (8'd1 << bit_sel);
            end
        end
        else
        begin
            // mostly short passes, now and then a long one
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(9, MAX_PASS)
                                               : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                pass_buf[i] = 8'($urandom);
        end

        // whatever the pass did, its contents are now the region's baseline
        if (hot)
        begin
            hot_len[slot] = len;
            for (int i = 0; i < len; i++)
                hot_bytes[slot][i] = pass_buf[i];
        end
        send_pass(op, region, len, $urandom_range(NOISE_NONE, NOISE_RANDOM));
    endtask

    // Hold the request side idle until every predicted result has come out.
    task automatic drain_results();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (results_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < 1024; i++)
            tracked[i] = 1'b0;
        hot_region[0] = 10'd0;
        hot_region[1] = 10'h3FF;
        hot_region[2] = 10'h155;
        hot_region[3] = 10'h2AA;
        for (int i = 0; i < HOT_COUNT; i++)
        begin
            hot_len[i] = 0;
            if (i >= 4)
                hot_region[i] = 10'(4 + i * 83);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed passes with light idling on both sides.
        ready_style = READY_RANDOM;
        gap_max     = 3;

        // single-byte passes at the region and byte extremes
        pass_buf[0] = 8'h00;
        send_pass(rcd_pkg::OP_TRACK, 10'd0, 1, NOISE_NONE);
        pass_buf[0] = 8'hFF;
        send_pass(rcd_pkg::OP_TRACK, 10'h3FF, 1, NOISE_NONE);
        pass_buf[0] = 8'h00;
        send_pass(rcd_pkg::OP_CHECK, 10'd0, 1, NOISE_NONE);     // unchanged
        send_pass(rcd_pkg::OP_CHECK, 10'h3FF, 1, NOISE_NONE);   // change, epoch 0
        send_pass(rcd_pkg::OP_CHECK, 10'h3FF, 1, NOISE_NONE);   // unchanged, epoch 1
        pass_buf[0] = 8'hFF;
        send_pass(rcd_pkg::OP_CHECK, 10'h3FF, 1, NOISE_NONE);   // change, epoch 1
        send_pass(rcd_pkg::OP_TRACK, 10'h3FF, 1, NOISE_NONE);   // track clears the epoch
        pass_buf[0] = 8'h5A;
        send_pass(rcd_pkg::OP_CHECK, 10'h3FF, 1, NOISE_NONE);   // change, epoch 0 again

        // multi-byte passes whose leading bytes carry the opposite op and
        // the complemented region; only the final byte may decide
        pass_buf[0] = 8'hAA;
        pass_buf[1] = 8'h55;
        pass_buf[2] = 8'h00;
        pass_buf[3] = 8'hFF;
        send_pass(rcd_pkg::OP_TRACK, 10'h155, 4, NOISE_INVERT);
        send_pass(rcd_pkg::OP_TRACK, 10'h2AA, 4, NOISE_INVERT);
        send_pass(rcd_pkg::OP_CHECK, 10'h155, 4, NOISE_INVERT); // unchanged
        drain_results();

        // Random phases: first with no idling at all, then ever harsher
        // sender gaps and receiver stalls. Every phase ends with a full drain.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    ready_style = READY_ALWAYS;
                    gap_max     = 0;
                end
                1:
                begin
                    ready_style = READY_RANDOM;
                    gap_max     = 4;
                end
                2:
                begin
                    ready_style = READY_PATTERN;
                    gap_max     = 12;
                end
                default:
                begin
                    ready_style = READY_LONG_STALL;
                    gap_max     = 25;
                end
            endcase
            begin : phase_body
                int phase_end;
                phase_end = items_sent + PHASE_ITEMS;
                while (items_sent < phase_end)
                    random_pass();
            end
            drain_results();
        end

        $display("Streamed %0d bytes in %0d track and check passes under four stall styles",
                 items_sent, passes_sent);
        $display("Compared %0d pass results, %0d of them reporting a changed region",
                 results_seen, changes_seen);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding", results_waiting);
        $display("Some tests failed");
        $finish;
    end

endmodule
